// File: design/flm_pkg.sv
// Shared constants, types and codes for the frame latency monitor.
package flm_pkg;

  localparam int unsigned HIST_DEPTH  = 256;
  localparam int unsigned HIST_AW     = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W       = $clog2(HIST_DEPTH + 1);
  localparam int unsigned TIME_W      = 20;
  localparam int unsigned START_W     = 48;
  localparam int unsigned SUM_W       = TIME_W + HIST_AW;
  localparam int unsigned DIP_W       = 32;
  localparam int unsigned WORST_DEPTH = 8;
  localparam int unsigned WIDX_W      = 3;
  localparam int unsigned WCNT_W      = 4;
  localparam int unsigned DIV_CNT_W   = $clog2(SUM_W + 1);
  localparam logic [TIME_W-1:0] THRESH_RST = 20'd33334;

  typedef enum logic [1:0] {
    OP_FRAME     = 2'd0,
    OP_READ      = 2'd1,
    OP_CLR_WORST = 2'd2,
    OP_CLR_ALL   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDOLD,
    S_UPD,
    S_SCAN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic               vld;
    logic [TIME_W-1:0]  ftime;
    logic [START_W-1:0] fstart;
  } entry_t;

  typedef struct packed {
    logic               ins;
    logic               clr;
    logic [TIME_W-1:0]  ftime;
    logic [START_W-1:0] fstart;
  } cell_ctl_t;

endpackage

// File: design/frame_latency_monitor.sv
// Frame latency monitor top level: history ring, window walk, worst-list chain, output stage.
// Flow: a frame word reads its oldest history entry (S_RDOLD) and updates (S_UPD); other
//   words go straight to S_UPD. S_SCAN then walks the held frames (at most 256) one entry per
//   cycle while the divider runs alongside; S_OUT loads one result per list entry on a read.
// Throughput: one word at a time; the next is taken once all results are loaded.
// Reset: asynchronous, active low; clears control, counts, sum, list valid bits and
//   the threshold (33334). The history memory is not cleared.
module frame_latency_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [flm_pkg::TIME_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic [flm_pkg::TIME_W-1:0]  frame_time_i,
  input  logic [flm_pkg::START_W-1:0] frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [flm_pkg::TIME_W-1:0]  average_time_o,
  output logic [flm_pkg::TIME_W-1:0]  window_worst_o,
  output logic [flm_pkg::DIP_W-1:0]   dip_total_o,
  output logic [flm_pkg::CNT_W-1:0]   frames_held_o,
  output logic                        was_dip_o,
  output logic                        entry_valid_o,
  output logic [flm_pkg::WIDX_W-1:0]  entry_rank_o,
  output logic [flm_pkg::TIME_W-1:0]  entry_time_o,
  output logic [flm_pkg::START_W-1:0] entry_start_o,
  output logic                        last_o
);

  flm_pkg::state_e state_q, state_d;

  logic [flm_pkg::TIME_W-1:0]  thresh_q;
  logic [1:0]                  op_q;
  logic [flm_pkg::TIME_W-1:0]  t_q;
  logic [flm_pkg::START_W-1:0] start_q;
  logic [flm_pkg::START_W-1:0] epoch_q;
  logic                        epoch_known_q;
  logic [flm_pkg::HIST_AW-1:0] head_q;
  logic [flm_pkg::CNT_W-1:0]   count_q;
  logic [flm_pkg::SUM_W-1:0]   sum_q;
  logic [flm_pkg::DIP_W-1:0]   dips_q;
  logic                        dip_q;
  logic [flm_pkg::CNT_W-1:0]   scan_q;
  logic                        rd_vld_q;
  logic [flm_pkg::TIME_W-1:0]  max_q;
  logic                        div_go_q;
  logic [flm_pkg::WIDX_W-1:0]  k_q;

  logic [flm_pkg::TIME_W-1:0]  mem [flm_pkg::HIST_DEPTH];
  logic [flm_pkg::TIME_W-1:0]  rdata_q;
  logic [flm_pkg::HIST_AW-1:0] raddr;
  logic                        we;

  logic                        in_acc, is_dip, scan_rd, scan_end, ld, multi, last_k;
  logic                        div_start, div_done;
  logic [flm_pkg::TIME_W-1:0]  quot;
  logic [flm_pkg::WCNT_W-1:0]  wcnt;
  logic [flm_pkg::WORST_DEPTH-1:0] wvld;

  logic                        out_valid_q;
  logic [flm_pkg::TIME_W-1:0]  avg_q, wworst_q, etime_q;
  logic [flm_pkg::DIP_W-1:0]   dtot_q;
  logic [flm_pkg::CNT_W-1:0]   held_q;
  logic                        wdip_q, evld_q, last_q;
  logic [flm_pkg::WIDX_W-1:0]  erank_q;
  logic [flm_pkg::START_W-1:0] estart_q;

  flm_pkg::cell_ctl_t ctl;
  flm_pkg::entry_t    ent  [flm_pkg::WORST_DEPTH];
  flm_pkg::entry_t    prev [flm_pkg::WORST_DEPTH];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == flm_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_dip      = (op_q == flm_pkg::OP_FRAME) && (t_q >= thresh_q);

  // worst-list chain
  assign ctl.ins    = (state_q == flm_pkg::S_UPD) && is_dip;
  assign ctl.clr    = (state_q == flm_pkg::S_UPD) &&
                      ((op_q == flm_pkg::OP_CLR_WORST) || (op_q == flm_pkg::OP_CLR_ALL));
  assign ctl.ftime  = t_q;
  assign ctl.fstart = start_q - epoch_q;

  for (genvar g = 0; g < flm_pkg::WORST_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev[g] = '{vld: 1'b1, ftime: '1, fstart: '0};
    end else begin : g_link
      assign prev[g] = ent[g-1];
    end
    flm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .prev_i (prev[g]),
      .ent_o  (ent[g])
    );
    assign wvld[g] = ent[g].vld;
  end

  assign wcnt = flm_pkg::WCNT_W'($countones(wvld));

  // history memory
  assign scan_rd  = (state_q == flm_pkg::S_SCAN) && (scan_q < count_q);
  assign raddr    = (state_q == flm_pkg::S_RDOLD) ? head_q : scan_q[flm_pkg::HIST_AW-1:0];
  assign we       = (state_q == flm_pkg::S_UPD) && (op_q == flm_pkg::OP_FRAME);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[head_q] <= t_q;
    end
    rdata_q <= mem[raddr];
  end

  assign div_start = (state_q == flm_pkg::S_SCAN) && !div_go_q;
  assign scan_end  = div_go_q && div_done && !scan_rd && !rd_vld_q;

  flm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign ld     = !out_valid_q || out_ready_i;
  assign multi  = (op_q == flm_pkg::OP_READ) && (wcnt != '0);
  assign last_k = ({1'b0, k_q} + 1'b1) == wcnt;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      flm_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (op_i == flm_pkg::OP_FRAME) ? flm_pkg::S_RDOLD : flm_pkg::S_UPD;
        end
      end
      flm_pkg::S_RDOLD: state_d = flm_pkg::S_UPD;
      flm_pkg::S_UPD:   state_d = flm_pkg::S_SCAN;
      flm_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = flm_pkg::S_OUT;
        end
      end
      flm_pkg::S_OUT: begin
        if (ld && (!multi || last_k)) begin
          state_d = flm_pkg::S_IDLE;
        end
      end
      default: state_d = flm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q      <= flm_pkg::THRESH_RST;
      epoch_known_q <= 1'b0;
      epoch_q       <= '0;
      head_q        <= '0;
      count_q       <= '0;
      sum_q         <= '0;
      dips_q        <= '0;
      dip_q         <= 1'b0;
      scan_q        <= '0;
      rd_vld_q      <= 1'b0;
      max_q         <= '0;
      div_go_q      <= 1'b0;
      k_q           <= '0;
    end else begin
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
      rd_vld_q <= scan_rd;
      if (in_acc) begin
        if ((op_i == flm_pkg::OP_FRAME) && !epoch_known_q) begin
          epoch_q       <= frame_start_i;
          epoch_known_q <= 1'b1;
        end
      end
      if (state_q == flm_pkg::S_UPD) begin
        dip_q    <= is_dip;
        scan_q   <= '0;
        max_q    <= '0;
        div_go_q <= 1'b0;
        k_q      <= '0;
        unique case (op_q)
          flm_pkg::OP_FRAME: begin
            if (count_q == flm_pkg::CNT_W'(flm_pkg::HIST_DEPTH)) begin
              sum_q <= sum_q - flm_pkg::SUM_W'(rdata_q) + flm_pkg::SUM_W'(t_q);
            end else begin
              sum_q   <= sum_q + flm_pkg::SUM_W'(t_q);
              count_q <= count_q + 1'b1;
            end
            head_q <= (head_q == flm_pkg::HIST_AW'(flm_pkg::HIST_DEPTH - 1)) ?
                      '0 : head_q + 1'b1;
            if (is_dip && (dips_q != '1)) begin
              dips_q <= dips_q + 1'b1;
            end
          end
          flm_pkg::OP_READ: ;
          flm_pkg::OP_CLR_WORST: dips_q <= '0;
          flm_pkg::OP_CLR_ALL: begin
            dips_q        <= '0;
            head_q        <= '0;
            count_q       <= '0;
            sum_q         <= '0;
            epoch_q       <= '0;
            epoch_known_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_q == flm_pkg::S_SCAN) begin
        div_go_q <= 1'b1;
        if (scan_rd) begin
          scan_q <= scan_q + 1'b1;
        end
        if (rd_vld_q && (rdata_q > max_q)) begin
          max_q <= rdata_q;
        end
      end
      if ((state_q == flm_pkg::S_OUT) && ld && multi) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_i;
      t_q     <= frame_time_i;
      start_q <= frame_start_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == flm_pkg::S_OUT) && ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == flm_pkg::S_OUT) && ld) begin
      avg_q    <= (count_q == '0) ? '0 : quot;
      wworst_q <= max_q;
      dtot_q   <= dips_q;
      held_q   <= count_q;
      wdip_q   <= dip_q;
      if (multi) begin
        evld_q   <= 1'b1;
        erank_q  <= k_q;
        etime_q  <= ent[k_q].ftime;
        estart_q <= ent[k_q].fstart;
        last_q   <= last_k;
      end else begin
        evld_q   <= 1'b0;
        erank_q  <= '0;
        etime_q  <= '0;
        estart_q <= '0;
        last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_time_o = avg_q;
  assign window_worst_o = wworst_q;
  assign dip_total_o    = dtot_q;
  assign frames_held_o  = held_q;
  assign was_dip_o      = wdip_q;
  assign entry_valid_o  = evld_q;
  assign entry_rank_o   = erank_q;
  assign entry_time_o   = etime_q;
  assign entry_start_o  = estart_q;
  assign last_o         = last_q;

  a_list_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((wvld & (wvld + 1'b1)) == '0))
    else $error("worst list valid bits not contiguous");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= flm_pkg::CNT_W'(flm_pkg::HIST_DEPTH))
    else $error("window count out of range");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0))
    else $error("empty window with nonzero sum");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("new word taken while one is in progress");

endmodule

// File: design/flm_cell.sv
// One slot of the sorted worst list; takes a new word or its neighbor's on insert.
module flm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flm_pkg::cell_ctl_t ctl_i,
  input  flm_pkg::entry_t    prev_i,
  output flm_pkg::entry_t    ent_o
);

  logic                        vld_q;
  logic [flm_pkg::TIME_W-1:0]  time_q;
  logic [flm_pkg::START_W-1:0] start_q;
  logic keep, take_new;

  assign keep     = vld_q && (time_q >= ctl_i.ftime);
  assign take_new = prev_i.vld && (prev_i.ftime >= ctl_i.ftime);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.clr) begin
      vld_q <= 1'b0;
    end else if (ctl_i.ins && !keep && prev_i.vld) begin
      vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins && !keep) begin
      if (take_new) begin
        time_q  <= ctl_i.ftime;
        start_q <= ctl_i.fstart;
      end else if (prev_i.vld) begin
        time_q  <= prev_i.ftime;
        start_q <= prev_i.fstart;
      end
    end
  end

  assign ent_o = '{vld: vld_q, ftime: time_q, fstart: start_q};

endmodule

// File: design/flm_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
module flm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [flm_pkg::SUM_W-1:0]   dividend_i,
  input  logic [flm_pkg::CNT_W-1:0]   divisor_i,
  output logic [flm_pkg::TIME_W-1:0]  quot_o,
  output logic                        done_o
);

  logic                           busy_q;
  logic [flm_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [flm_pkg::SUM_W-1:0]      quo_q;
  logic [flm_pkg::CNT_W-1:0]      rem_q;
  logic [flm_pkg::CNT_W-1:0]      dvs_q;
  logic [flm_pkg::CNT_W:0]        shifted, trial;

  assign shifted = {rem_q, quo_q[flm_pkg::SUM_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= flm_pkg::DIV_CNT_W'(flm_pkg::SUM_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != flm_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[flm_pkg::CNT_W]) begin
        rem_q <= trial[flm_pkg::CNT_W-1:0];
        quo_q <= {quo_q[flm_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[flm_pkg::CNT_W-1:0];
        quo_q <= {quo_q[flm_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot_o = quo_q[flm_pkg::TIME_W-1:0];
  assign done_o = !busy_q;

endmodule

// File: sim/frame_latency_monitor_tb.sv
// Testbench for frame_latency_monitor: directed and random words checked against a local model.
`timescale 1ns / 1ps
module frame_latency_monitor_tb;

  typedef struct {
    logic [flm_pkg::TIME_W-1:0]  avg;
    logic [flm_pkg::TIME_W-1:0]  wmax;
    logic [flm_pkg::DIP_W-1:0]   dips;
    logic [flm_pkg::CNT_W-1:0]   held;
    logic                        dip;
    logic                        evld;
    logic [flm_pkg::WIDX_W-1:0]  rank;
    logic [flm_pkg::TIME_W-1:0]  etime;
    logic [flm_pkg::START_W-1:0] estart;
    logic                        lst;
  } stats_t;

  localparam int unsigned EXP_DEPTH = 4096;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [flm_pkg::TIME_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = flm_pkg::OP_FRAME;
  logic [flm_pkg::TIME_W-1:0] ftime = '0;
  logic [flm_pkg::START_W-1:0] fstart = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [flm_pkg::TIME_W-1:0] avg_o, wmax_o, etime_o;
  logic [flm_pkg::DIP_W-1:0] dips_o;
  logic [flm_pkg::CNT_W-1:0] held_o;
  logic dip_o, evld_o, last_o;
  logic [flm_pkg::WIDX_W-1:0] rank_o;
  logic [flm_pkg::START_W-1:0] estart_o;

  // model state
  logic [flm_pkg::TIME_W-1:0]  m_thresh;
  logic [flm_pkg::TIME_W-1:0]  m_ring [flm_pkg::HIST_DEPTH];
  int unsigned                 m_head, m_count;
  longint unsigned             m_sum;
  logic [flm_pkg::DIP_W-1:0]   m_dips;
  logic [flm_pkg::TIME_W-1:0]  m_wtime [flm_pkg::WORST_DEPTH];
  logic [flm_pkg::START_W-1:0] m_wstart [flm_pkg::WORST_DEPTH];
  int unsigned                 m_wcount;
  logic [flm_pkg::START_W-1:0] m_epoch;
  logic                        m_epoch_known;

  stats_t exp_mem [EXP_DEPTH];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  bit calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  frame_latency_monitor u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .op_i(op), .frame_time_i(ftime), .frame_start_i(fstart),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .average_time_o(avg_o), .window_worst_o(wmax_o), .dip_total_o(dips_o),
    .frames_held_o(held_o), .was_dip_o(dip_o), .entry_valid_o(evld_o),
    .entry_rank_o(rank_o), .entry_time_o(etime_o), .entry_start_o(estart_o),
    .last_o(last_o)
  );

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 22);
  endfunction

  function automatic stats_t window_stats();
    stats_t r;
    logic [flm_pkg::TIME_W-1:0] mx;
    mx = '0;
    for (int i = 0; i < m_count; i++) if (m_ring[i] > mx) mx = m_ring[i];
    r.avg = (m_count != 0) ? flm_pkg::TIME_W'(m_sum / m_count) : '0;
    r.wmax = mx;
    r.dips = m_dips;
    r.held = flm_pkg::CNT_W'(m_count);
    r.dip = 1'b0; r.evld = 1'b0; r.rank = '0; r.etime = '0; r.estart = '0; r.lst = 1'b0;
    return r;
  endfunction

  task automatic add_expected(stats_t r);
    if (exp_wr >= EXP_DEPTH) begin
      $error("expected store overflow");
      errors++;
    end else begin
      exp_mem[exp_wr] = r;
      exp_wr++;
    end
  endtask

  task automatic model_clear_worst();
    m_wcount = 0;
    m_dips = '0;
  endtask

  task automatic model_clear_all();
    m_head = 0; m_count = 0; m_sum = 0;
    model_clear_worst();
    m_epoch = '0; m_epoch_known = 1'b0;
  endtask

  task automatic predict_word(logic [1:0] o, logic [flm_pkg::TIME_W-1:0] t,
                              logic [flm_pkg::START_W-1:0] s);
    stats_t r;
    bit is_dip;
    int unsigned pos, i;
    is_dip = 1'b0;
    case (o)
      flm_pkg::OP_FRAME: begin
        if (!m_epoch_known) begin
          m_epoch = s; m_epoch_known = 1'b1;
        end
        if (m_count >= flm_pkg::HIST_DEPTH) m_sum -= m_ring[m_head];
        else m_count++;
        m_ring[m_head] = t;
        m_sum += t;
        m_head = (m_head + 1) % flm_pkg::HIST_DEPTH;
        if (t >= m_thresh) begin
          is_dip = 1'b1;
          if (m_dips != '1) m_dips++;
          pos = 0;
          while (pos < m_wcount && m_wtime[pos] >= t) pos++;
          if (pos < flm_pkg::WORST_DEPTH) begin
            i = (m_wcount < flm_pkg::WORST_DEPTH) ? m_wcount : flm_pkg::WORST_DEPTH - 1;
            while (i > pos) begin
              m_wtime[i] = m_wtime[i-1]; m_wstart[i] = m_wstart[i-1]; i--;
            end
            m_wtime[pos] = t;
            m_wstart[pos] = s - m_epoch;
            if (m_wcount < flm_pkg::WORST_DEPTH) m_wcount++;
          end
        end
      end
      flm_pkg::OP_READ: begin
        if (m_wcount != 0) begin
          for (int k = 0; k < m_wcount; k++) begin
            r = window_stats();
            r.evld = 1'b1; r.rank = flm_pkg::WIDX_W'(k);
            r.etime = m_wtime[k]; r.estart = m_wstart[k];
            r.lst = (k + 1 == m_wcount);
            add_expected(r);
          end
          return;
        end
      end
      flm_pkg::OP_CLR_WORST: model_clear_worst();
      default: model_clear_all();
    endcase
    r = window_stats();
    r.dip = is_dip;
    r.lst = 1'b1;
    add_expected(r);
  endtask

  // entered at a falling edge; leaves at the falling edge after acceptance, valid still high
  task automatic send_word(logic [1:0] o, logic [flm_pkg::TIME_W-1:0] t,
                           logic [flm_pkg::START_W-1:0] s);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o; ftime <= t; fstart <= s;
    predict_word(o, t, s);
    words_sent++;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_rd != exp_wr) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_threshold(logic [flm_pkg::TIME_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    m_thresh = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) out_ready <= !idle_now();

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      stats_t e;
      results_seen++;
      if (exp_rd == exp_wr) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = exp_mem[exp_rd];
        exp_rd++;
        if (avg_o !== e.avg) begin
          $error("average_time exp %0d got %0d", e.avg, avg_o); errors++;
        end
        if (wmax_o !== e.wmax) begin
          $error("window_worst exp %0d got %0d", e.wmax, wmax_o); errors++;
        end
        if (dips_o !== e.dips) begin
          $error("dip_total exp %0d got %0d", e.dips, dips_o); errors++;
        end
        if (held_o !== e.held) begin
          $error("frames_held exp %0d got %0d", e.held, held_o); errors++;
        end
        if (dip_o !== e.dip) begin
          $error("was_dip exp %0d got %0d", e.dip, dip_o); errors++;
        end
        if (evld_o !== e.evld) begin
          $error("entry_valid exp %0d got %0d", e.evld, evld_o); errors++;
        end
        if (rank_o !== e.rank) begin
          $error("entry_rank exp %0d got %0d", e.rank, rank_o); errors++;
        end
        if (etime_o !== e.etime) begin
          $error("entry_time exp %0d got %0d", e.etime, etime_o); errors++;
        end
        if (estart_o !== e.estart) begin
          $error("entry_start exp %0h got %0h", e.estart, estart_o); errors++;
        end
        if (last_o !== e.lst) begin
          $error("last exp %0d got %0d", e.lst, last_o); errors++;
        end
      end
    end
  end

  task automatic test_empty();
    send_word(flm_pkg::OP_READ, '0, '0);
    send_word(flm_pkg::OP_CLR_WORST, '0, '0);
    send_word(flm_pkg::OP_CLR_ALL, '1, '1);
  endtask

  task automatic test_worst_list();
    // epoch late so later starts wrap below it
    send_word(flm_pkg::OP_FRAME, 20'd40000, 48'h8000_0000_0000);
    send_word(flm_pkg::OP_FRAME, 20'd50000, 48'h0000_0000_0010);
    send_word(flm_pkg::OP_FRAME, 20'd100, 48'hFFFF_FFFF_FFFF);
    send_word(flm_pkg::OP_FRAME, 20'd40000, 48'h8000_0000_0100);
    send_word(flm_pkg::OP_FRAME, '1, 48'h8000_0000_0200);
    for (int i = 0; i < 6; i++) begin
      send_word(flm_pkg::OP_FRAME, 20'd40000, 48'h8000_0001_0000 + i);
    end
    send_word(flm_pkg::OP_READ, '0, '0);
    send_word(flm_pkg::OP_CLR_WORST, '0, '0);
    send_word(flm_pkg::OP_READ, '0, '0);
    send_word(flm_pkg::OP_CLR_ALL, '0, '0);
  endtask

  task automatic test_thresholds();
    write_threshold('0);
    send_word(flm_pkg::OP_FRAME, '0, 48'h1234_5678_9ABC);
    send_word(flm_pkg::OP_READ, '0, '0);
    write_threshold('1);
    send_word(flm_pkg::OP_FRAME, 20'hFFFFE, 48'h0);
    send_word(flm_pkg::OP_FRAME, '1, 48'h5);
    send_word(flm_pkg::OP_READ, '0, '0);
    send_word(flm_pkg::OP_CLR_ALL, '0, '0);
  endtask

  task automatic test_random();
    int n, sel;
    logic [flm_pkg::TIME_W-1:0] t;
    write_threshold(20'($urandom_range(1048575)));
    send_word(flm_pkg::OP_CLR_ALL, '0, '0);
    for (n = 0; n < 90; n++) begin
      if (n == 30) calm = 1'b1;
      if (n == 55) calm = 1'b0;
      if (n == 45) begin
        write_threshold(20'($urandom_range(60000, 1000)));
      end
      sel = $urandom_range(99);
      if (sel < 40) t = m_thresh + 20'($urandom_range(3)) - 20'd1;
      else t = 20'($urandom);
      if (sel < 75) send_word(flm_pkg::OP_FRAME, t, {16'($urandom), 32'($urandom)});
      else if (sel < 88) send_word(flm_pkg::OP_READ, t, '0);
      else if (sel < 95) send_word(flm_pkg::OP_CLR_WORST, t, '1);
      else send_word(flm_pkg::OP_CLR_ALL, t, '0);
    end
    send_word(flm_pkg::OP_READ, '0, '0);
  endtask

  initial begin
    m_thresh = flm_pkg::THRESH_RST;
    model_clear_all();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_empty();
    test_worst_list();
    test_thresholds();
    test_random();
    drain();
    $display("sent %0d words, checked %0d result words", words_sent, results_seen);
    $display("covered empty reads, tied dips, list overflow, threshold extremes, random mix");
    if (errors == 0 && exp_rd == exp_wr) begin
      $display("frame_latency_monitor_tb: done, clean");
    end else begin
      $display("frame_latency_monitor_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("frame_latency_monitor_tb: done, errors");
    $finish;
  end

endmodule
